// File: rtl/ldm_pkg.sv
`default_nettype none

package ldm_pkg;

	localparam int COORD_W   = 16;
	localparam int OUT_W     = 18;
	localparam int Q_W       = 32;
	localparam int PROD_W    = 64;
	localparam int SCALE_W   = 49;
	localparam int TAN_W     = 35;
	localparam int CFG_IDX_W = 3;
	localparam int CFG_DATA_W = 32;
	localparam int DIV_LOW   = 4;
	localparam int DIV_STEPS = 32;
	localparam int DIV_LAT   = DIV_STEPS + 2;
	localparam int FRAC_BITS = 28;

	localparam logic signed [PROD_W-1:0] Q_ONE   = 64'sd268435456;
	localparam logic signed [PROD_W-1:0] Q_HALF  = 64'sd134217728;
	localparam logic signed [PROD_W-1:0] S32_MAX = 64'sd2147483647;
	localparam logic signed [PROD_W-1:0] S32_MIN = -64'sd2147483648;
	localparam logic signed [PROD_W-1:0] OUT_MAX = 64'sd131071;
	localparam logic signed [PROD_W-1:0] OUT_MIN = -64'sd131072;

	localparam logic [COORD_W-1:0] FOCAL_RST = 16'd16384;

	// register indexes of the configuration port
	typedef enum logic [CFG_IDX_W-1:0] {
		REG_FOCAL_X   = 3'd0,
		REG_FOCAL_Y   = 3'd1,
		REG_PRINCIPAL = 3'd2,
		REG_K1        = 3'd3,
		REG_K2        = 3'd4,
		REG_K3        = 3'd5,
		REG_P1        = 3'd6,
		REG_P2        = 3'd7
	} cfg_reg_t;

	typedef struct packed {
		logic [COORD_W-1:0]    focal_x;
		logic [COORD_W-1:0]    focal_y;
		logic [COORD_W-1:0]    cx;
		logic [COORD_W-1:0]    cy;
		logic signed [Q_W-1:0] k1;
		logic signed [Q_W-1:0] k2;
		logic signed [Q_W-1:0] k3;
		logic signed [Q_W-1:0] p1;
		logic signed [Q_W-1:0] p2;
	} cfg_t;

	function automatic logic signed [PROD_W-1:0] sx(input logic signed [Q_W-1:0] a);
		return {{(PROD_W-Q_W){a[Q_W-1]}}, a};
	endfunction

	function automatic logic signed [Q_W-1:0] sat64(input logic signed [PROD_W-1:0] v);
		logic signed [Q_W-1:0] r;
		if (v > S32_MAX)
			r = S32_MAX[Q_W-1:0];
		else if (v < S32_MIN)
			r = S32_MIN[Q_W-1:0];
		else
			r = v[Q_W-1:0];
		return r;
	endfunction

	// Q4.28 product: round half up, then saturate
	function automatic logic signed [Q_W-1:0] qround(input logic signed [PROD_W-1:0] p);
		logic signed [PROD_W-1:0] t;
		t = (p + Q_HALF) >>> FRAC_BITS;
		return sat64(t);
	endfunction

endpackage

`default_nettype wire

// File: rtl/ldm_div.sv
`default_nettype none

// One normalize lane: (point - center) * 2^28 / focal, restoring divide,
// one quotient bit per stage, saturated to Q4.28.
module ldm_div (
	input  wire logic                        clk,
	input  wire logic                        en,
	input  wire logic [ldm_pkg::COORD_W-1:0] pt,
	input  wire logic [ldm_pkg::COORD_W-1:0] ctr,
	input  wire logic [ldm_pkg::COORD_W-1:0] fl,
	output logic signed [ldm_pkg::Q_W-1:0]   q
);
	import ldm_pkg::*;

	logic signed [COORD_W:0] diff;
	logic                    neg_c;
	logic [COORD_W-1:0]      mag_c;

	logic [COORD_W-1:0] rem_s  [0:DIV_STEPS];
	logic [Q_W-1:0]     quo_s  [0:DIV_STEPS];
	logic [DIV_LOW-1:0] low_s  [0:DIV_STEPS];
	logic               neg_s  [0:DIV_STEPS];
	logic               ovf_s  [0:DIV_STEPS];
	logic               zero_s [0:DIV_STEPS];
	logic signed [Q_W-1:0] norm_s;
	logic               big;

	// sign and magnitude of the offset from the center
	assign diff  = $signed({1'b0, pt}) - $signed({1'b0, ctr});
	assign neg_c = diff[COORD_W];
	assign mag_c = neg_c ? COORD_W'(-diff) : diff[COORD_W-1:0];

	// prep stage: quotient of 2^32 or more is flagged up front
	always_ff @(posedge clk) begin
		if (en) begin
			rem_s[0]  <= {{DIV_LOW{1'b0}}, mag_c[COORD_W-1:DIV_LOW]};
			low_s[0]  <= mag_c[DIV_LOW-1:0];
			quo_s[0]  <= '0;
			neg_s[0]  <= neg_c;
			ovf_s[0]  <= {{DIV_LOW{1'b0}}, mag_c} >= {fl, {DIV_LOW{1'b0}}};
			zero_s[0] <= (mag_c == '0);
		end
	end

	// one trial subtract per stage
	for (genvar j = 0; j < DIV_STEPS; j++) begin : g_step
		logic            bit_in;
		logic [COORD_W:0] trial;
		logic [COORD_W:0] sub;
		logic            ge;

		if (j < DIV_LOW) begin : g_low
			assign bit_in = low_s[j][DIV_LOW-1-j];
		end else begin : g_zero
			assign bit_in = 1'b0;
		end

		assign trial = {rem_s[j], bit_in};
		assign ge    = trial >= {1'b0, fl};
		assign sub   = trial - {1'b0, fl};

		always_ff @(posedge clk) begin
			if (en) begin
				rem_s[j+1]  <= ge ? sub[COORD_W-1:0] : trial[COORD_W-1:0];
				quo_s[j+1]  <= {quo_s[j][Q_W-2:0], ge};
				low_s[j+1]  <= low_s[j];
				neg_s[j+1]  <= neg_s[j];
				ovf_s[j+1]  <= ovf_s[j];
				zero_s[j+1] <= zero_s[j];
			end
		end
	end

	// apply sign and clamp to full scale
	assign big = ovf_s[DIV_STEPS] | quo_s[DIV_STEPS][Q_W-1];

	always_ff @(posedge clk) begin
		if (en) begin
			if (zero_s[DIV_STEPS])
				norm_s <= '0;
			else if (neg_s[DIV_STEPS])
				norm_s <= big ? S32_MIN[Q_W-1:0] : -$signed(quo_s[DIV_STEPS]);
			else
				norm_s <= big ? S32_MAX[Q_W-1:0] : $signed(quo_s[DIV_STEPS]);
		end
	end

	assign q = norm_s;

endmodule

`default_nettype wire

// File: rtl/ldm_poly.sv
`default_nettype none

// Distortion polynomial and rescale: alternating multiply and
// round/add stages, twelve in all.
module ldm_poly (
	input  wire logic                       clk,
	input  wire logic                       arst_n,
	input  wire logic                       en,
	input  wire logic                       vld_in,
	input  wire logic signed [ldm_pkg::Q_W-1:0] x,
	input  wire logic signed [ldm_pkg::Q_W-1:0] y,
	input  wire ldm_pkg::cfg_t              cfg,
	output logic                            vld_out,
	output logic signed [ldm_pkg::OUT_W-1:0] mx,
	output logic signed [ldm_pkg::OUT_W-1:0] my,
	output logic                            clip
);
	import ldm_pkg::*;

	localparam int NSTG = 12;

	logic [NSTG:1] vld_s;

	logic signed [PROD_W-1:0] pxx_s1, pyy_s1, pxy_s1;
	logic signed [Q_W-1:0]    x_s1, y_s1;
	logic signed [Q_W-1:0]    r2_s2, xy_s2, t2x_s2, t2y_s2, x_s2, y_s2;
	logic signed [PROD_W-1:0] pr4_s3, pk1_s3, pp1xy_s3, pp2xy_s3, pp2t_s3, pp1t_s3;
	logic signed [Q_W-1:0]    r2_s3, x_s3, y_s3;
	logic signed [Q_W-1:0]    r4_s4, k1r2_s4, r2_s4, x_s4, y_s4;
	logic signed [TAN_W-1:0]  tx_s4, ty_s4;
	logic signed [PROD_W-1:0] pr6_s5, pk2_s5;
	logic signed [Q_W-1:0]    k1r2_s5, x_s5, y_s5;
	logic signed [TAN_W-1:0]  tx_s5, ty_s5;
	logic signed [Q_W-1:0]    r6_s6, k2r4_s6, k1r2_s6, x_s6, y_s6;
	logic signed [TAN_W-1:0]  tx_s6, ty_s6;
	logic signed [PROD_W-1:0] pk3_s7;
	logic signed [Q_W-1:0]    k2r4_s7, k1r2_s7, x_s7, y_s7;
	logic signed [TAN_W-1:0]  tx_s7, ty_s7;
	logic signed [Q_W-1:0]    radial_s8, x_s8, y_s8;
	logic signed [TAN_W-1:0]  tx_s8, ty_s8;
	logic signed [PROD_W-1:0] pxr_s9, pyr_s9;
	logic signed [TAN_W-1:0]  tx_s9, ty_s9;
	logic signed [Q_W-1:0]    xd_s10, yd_s10;
	logic signed [SCALE_W-1:0] pfx_s11, pfy_s11;
	logic signed [OUT_W-1:0]  mx_s12, my_s12;
	logic                     clip_s12;

	logic signed [Q_W-1:0]    xx_c, yy_c, r2_c;
	logic signed [PROD_W-1:0] vx_c, vy_c;
	logic                     hx_c, lx_c, hy_c, ly_c;

	// valid bits
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			vld_s <= '0;
		else if (en)
			vld_s <= {vld_s[NSTG-1:1], vld_in};
	end

	// r squared and the doubled-square sums
	assign xx_c = qround(pxx_s1);
	assign yy_c = qround(pyy_s1);
	assign r2_c = sat64(sx(xx_c) + sx(yy_c));

	// rescale to pixels
	assign vx_c = ((64'(pfx_s11) + Q_HALF) >>> FRAC_BITS) + $signed({48'd0, cfg.cx});
	assign vy_c = ((64'(pfy_s11) + Q_HALF) >>> FRAC_BITS) + $signed({48'd0, cfg.cy});
	assign hx_c = vx_c > OUT_MAX;
	assign lx_c = vx_c < OUT_MIN;
	assign hy_c = vy_c > OUT_MAX;
	assign ly_c = vy_c < OUT_MIN;

	always_ff @(posedge clk) begin
		if (en) begin
			// squares and cross product
			pxx_s1 <= x * x;
			pyy_s1 <= y * y;
			pxy_s1 <= x * y;
			x_s1   <= x;
			y_s1   <= y;
			// round and sum
			r2_s2  <= r2_c;
			xy_s2  <= qround(pxy_s1);
			t2x_s2 <= sat64(sx(r2_c) + 2 * sx(xx_c));
			t2y_s2 <= sat64(sx(r2_c) + 2 * sx(yy_c));
			x_s2   <= x_s1;
			y_s2   <= y_s1;
			// r^4, k1 term and tangential products
			pr4_s3   <= r2_s2 * r2_s2;
			pk1_s3   <= cfg.k1 * r2_s2;
			pp1xy_s3 <= cfg.p1 * xy_s2;
			pp2xy_s3 <= cfg.p2 * xy_s2;
			pp2t_s3  <= cfg.p2 * t2x_s2;
			pp1t_s3  <= cfg.p1 * t2y_s2;
			r2_s3    <= r2_s2;
			x_s3     <= x_s2;
			y_s3     <= y_s2;
			// tangential sums kept exact
			r4_s4   <= qround(pr4_s3);
			k1r2_s4 <= qround(pk1_s3);
			tx_s4   <= TAN_W'(2 * sx(qround(pp1xy_s3)) + sx(qround(pp2t_s3)));
			ty_s4   <= TAN_W'(sx(qround(pp1t_s3)) + 2 * sx(qround(pp2xy_s3)));
			r2_s4   <= r2_s3;
			x_s4    <= x_s3;
			y_s4    <= y_s3;
			// r^6 and k2 term
			pr6_s5  <= r4_s4 * r2_s4;
			pk2_s5  <= cfg.k2 * r4_s4;
			k1r2_s5 <= k1r2_s4;
			tx_s5   <= tx_s4;
			ty_s5   <= ty_s4;
			x_s5    <= x_s4;
			y_s5    <= y_s4;
			r6_s6   <= qround(pr6_s5);
			k2r4_s6 <= qround(pk2_s5);
			k1r2_s6 <= k1r2_s5;
			tx_s6   <= tx_s5;
			ty_s6   <= ty_s5;
			x_s6    <= x_s5;
			y_s6    <= y_s5;
			// k3 term
			pk3_s7  <= cfg.k3 * r6_s6;
			k2r4_s7 <= k2r4_s6;
			k1r2_s7 <= k1r2_s6;
			tx_s7   <= tx_s6;
			ty_s7   <= ty_s6;
			x_s7    <= x_s6;
			y_s7    <= y_s6;
			// radial factor
			radial_s8 <= sat64(Q_ONE + sx(k1r2_s7) + sx(k2r4_s7) + sx(qround(pk3_s7)));
			tx_s8     <= tx_s7;
			ty_s8     <= ty_s7;
			x_s8      <= x_s7;
			y_s8      <= y_s7;
			pxr_s9    <= x_s8 * radial_s8;
			pyr_s9    <= y_s8 * radial_s8;
			tx_s9     <= tx_s8;
			ty_s9     <= ty_s8;
			// distorted normalized point
			xd_s10 <= sat64(sx(qround(pxr_s9)) + 64'(tx_s9));
			yd_s10 <= sat64(sx(qround(pyr_s9)) + 64'(ty_s9));
			pfx_s11 <= xd_s10 * $signed({1'b0, cfg.focal_x});
			pfy_s11 <= yd_s10 * $signed({1'b0, cfg.focal_y});
			// saturate to Q14.4
			mx_s12 <= hx_c ? OUT_MAX[OUT_W-1:0] : (lx_c ? OUT_MIN[OUT_W-1:0] : vx_c[OUT_W-1:0]);
			my_s12 <= hy_c ? OUT_MAX[OUT_W-1:0] : (ly_c ? OUT_MIN[OUT_W-1:0] : vy_c[OUT_W-1:0]);
			clip_s12 <= hx_c | lx_c | hy_c | ly_c;
		end
	end

	assign vld_out = vld_s[NSTG];
	assign mx      = mx_s12;
	assign my      = my_s12;
	assign clip    = clip_s12;

endmodule

`default_nettype wire

// File: rtl/lens_distortion_point_mapper.sv
// Lens distortion point mapper, five-coefficient radial/tangential model.
//
// Input channel: in_valid / in_stall with point_x, point_y (unsigned Q12.4).
// Output channel: out_valid / out_stall with mapped_x, mapped_y (signed Q14.4,
// saturated) and clipped. An item moves when valid is high and stall is low.
// Configuration: cfg_we writes cfg_data to register cfg_index (0 focal_x,
// 1 focal_y, 2 principal point, 3..5 k1..k3, 6..7 p1, p2). Write only while
// no item is in flight.
//
// Throughput: one item per clock while in_stall is low. Path from the accepting edge
// to out_valid: 34 stages of bit-per-stage normalize divide, 12 stages of
// polynomial multiply and round, and the output register.
// A stalled result is held in the output register; one more result lands
// in a skid register, after which in_stall rises and the whole pipeline
// holds until the output is taken. No item is lost or repeated.
// Reset (arst_n low) empties the pipeline, sets focal lengths to 1024.0
// pixels and clears the principal point and all coefficients.
`default_nettype none

module lens_distortion_point_mapper (
	input  wire logic                           clk,
	input  wire logic                           arst_n,
	input  wire logic                           cfg_we,
	input  wire logic [ldm_pkg::CFG_IDX_W-1:0]  cfg_index,
	input  wire logic [ldm_pkg::CFG_DATA_W-1:0] cfg_data,
	input  wire logic                           in_valid,
	output logic                                in_stall,
	input  wire logic [ldm_pkg::COORD_W-1:0]    point_x,
	input  wire logic [ldm_pkg::COORD_W-1:0]    point_y,
	output logic                                out_valid,
	input  wire logic                           out_stall,
	output logic signed [ldm_pkg::OUT_W-1:0]    mapped_x,
	output logic signed [ldm_pkg::OUT_W-1:0]    mapped_y,
	output logic                                clipped
);
	import ldm_pkg::*;

	cfg_t cfg_q;
	logic en;
	logic [DIV_LAT-1:0] div_vld_s;
	logic signed [Q_W-1:0] nx, ny;
	logic p_vld;
	logic signed [OUT_W-1:0] p_mx, p_my;
	logic p_clip;

	logic out_vld_q, skid_full_q, clip_q, skid_clip_q;
	logic signed [OUT_W-1:0] mx_q, my_q, skid_mx_q, skid_my_q;
	logic out_take;

	// configuration registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q         <= '0;
			cfg_q.focal_x <= FOCAL_RST;
			cfg_q.focal_y <= FOCAL_RST;
		end else if (cfg_we) begin
			case (cfg_reg_t'(cfg_index))
				REG_FOCAL_X: cfg_q.focal_x <= cfg_data[COORD_W-1:0];
				REG_FOCAL_Y: cfg_q.focal_y <= cfg_data[COORD_W-1:0];
				REG_PRINCIPAL: begin
					cfg_q.cx <= cfg_data[COORD_W-1:0];
					cfg_q.cy <= cfg_data[2*COORD_W-1:COORD_W];
				end
				REG_K1: cfg_q.k1 <= $signed(cfg_data);
				REG_K2: cfg_q.k2 <= $signed(cfg_data);
				REG_K3: cfg_q.k3 <= $signed(cfg_data);
				REG_P1: cfg_q.p1 <= $signed(cfg_data);
				REG_P2: cfg_q.p2 <= $signed(cfg_data);
				default: ;
			endcase
		end
	end

	// whole pipeline advances unless the skid register is occupied
	assign en       = !skid_full_q;
	assign in_stall = skid_full_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			div_vld_s <= '0;
		else if (en)
			div_vld_s <= {div_vld_s[DIV_LAT-2:0], in_valid};
	end

	ldm_div u_div_x (
		.clk (clk), .en (en), .pt (point_x), .ctr (cfg_q.cx), .fl (cfg_q.focal_x), .q (nx)
	);

	ldm_div u_div_y (
		.clk (clk), .en (en), .pt (point_y), .ctr (cfg_q.cy), .fl (cfg_q.focal_y), .q (ny)
	);

	ldm_poly u_poly (
		.clk     (clk),
		.arst_n  (arst_n),
		.en      (en),
		.vld_in  (div_vld_s[DIV_LAT-1]),
		.x       (nx),
		.y       (ny),
		.cfg     (cfg_q),
		.vld_out (p_vld),
		.mx      (p_mx),
		.my      (p_my),
		.clip    (p_clip)
	);

	// output register with one skid entry
	assign out_take = out_vld_q && !out_stall;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_vld_q   <= 1'b0;
			skid_full_q <= 1'b0;
		end else if (skid_full_q) begin
			if (out_take)
				skid_full_q <= 1'b0;
		end else if (p_vld && out_vld_q && out_stall) begin
			skid_full_q <= 1'b1;
		end else if (p_vld) begin
			out_vld_q <= 1'b1;
		end else if (out_take) begin
			out_vld_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (skid_full_q) begin
			if (out_take) begin
				mx_q   <= skid_mx_q;
				my_q   <= skid_my_q;
				clip_q <= skid_clip_q;
			end
		end else if (p_vld && out_vld_q && out_stall) begin
			skid_mx_q   <= p_mx;
			skid_my_q   <= p_my;
			skid_clip_q <= p_clip;
		end else if (p_vld) begin
			mx_q   <= p_mx;
			my_q   <= p_my;
			clip_q <= p_clip;
		end
	end

	assign out_valid = out_vld_q;
	assign mapped_x  = mx_q;
	assign mapped_y  = my_q;
	assign clipped   = clip_q;

endmodule

`default_nettype wire

// File: rtl/ldm_checker.sv
`default_nettype none

module ldm_checker (
	input wire logic                        clk,
	input wire logic                        arst_n,
	input wire logic                        in_stall,
	input wire logic                        out_valid,
	input wire logic                        out_stall,
	input wire logic signed [ldm_pkg::OUT_W-1:0] mapped_x,
	input wire logic signed [ldm_pkg::OUT_W-1:0] mapped_y,
	input wire logic                        clipped
);
	import ldm_pkg::*;

	// a stalled result stays offered
	a_hold_valid: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_stall |=> out_valid)
		else $error("out_valid dropped under stall");

	// a stalled result does not change
	a_hold_data: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_stall |=> $stable(mapped_x) && $stable(mapped_y) && $stable(clipped))
		else $error("result changed under stall");

	// input backpressure only follows a stalled output
	a_stall_cause: assert property (@(posedge clk) disable iff (!arst_n)
		!(out_valid && out_stall) |=> !in_stall)
		else $error("in_stall without output backpressure");

	// clipped results sit at a rail
	a_clip_rail: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && clipped |->
			mapped_x == OUT_MAX[OUT_W-1:0] || mapped_x == OUT_MIN[OUT_W-1:0] ||
			mapped_y == OUT_MAX[OUT_W-1:0] || mapped_y == OUT_MIN[OUT_W-1:0])
		else $error("clipped set with no saturated coordinate");

endmodule

bind lens_distortion_point_mapper ldm_checker u_ldm_checker (
	.clk       (clk),
	.arst_n    (arst_n),
	.in_stall  (in_stall),
	.out_valid (out_valid),
	.out_stall (out_stall),
	.mapped_x  (mapped_x),
	.mapped_y  (mapped_y),
	.clipped   (clipped)
);

`default_nettype wire
